### sv/bpfm_pkg.sv
// Shared codes, widths and controller/datapath types of the buffer pool frame manager.
package bpfm_pkg;

    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int FRAME_W    = 4;
    localparam int IO_OP_W    = 2;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int LIMIT_W    = 5;

    localparam logic [MODE_W-1:0] MODE_PIN      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNPIN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DIRTY    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FORCE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PINNED   = 2'd3;

    localparam logic [IO_OP_W-1:0] IO_NONE  = 2'd0;
    localparam logic [IO_OP_W-1:0] IO_READ  = 2'd1;
    localparam logic [IO_OP_W-1:0] IO_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 4'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_PIN_HIT,
        OP_UNPIN,
        OP_DIRTY,
        OP_FORCE,
        OP_CODE,
        OP_FILL,
        OP_VSTART,
        OP_VSTEP,
        OP_WB,
        OP_LOAD,
        OP_FSTART,
        OP_FSTEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [STATUS_W-1:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              hit;
        logic              empty;
        logic              any_dirty;
        logic              any_pinned;
        logic              v_found;
        logic              v_dirty;
        logic              scan_last;
        logic              cur_dirty;
        logic              out_free;
    } dp_stat_t;

endpackage

### sv/bpfm_req_if.sv
// Request channel: mode and page number.
interface bpfm_req_if #(parameter int PAGE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic [bpfm_pkg::MODE_W-1:0]   mode;
    logic [PAGE_BITS-1:0]          page_num;

    modport source (output valid, output mode, output page_num, input ready);
    modport sink   (input valid, input mode, input page_num, output ready);
endinterface

### sv/bpfm_res_if.sv
// Result channel: status, frame, storage request and totals.
interface bpfm_res_if #(parameter int PAGE_BITS = 24);
    logic                           valid;
    logic                           ready;
    logic [bpfm_pkg::STATUS_W-1:0]  status;
    logic [bpfm_pkg::FRAME_W-1:0]   frame;
    logic [bpfm_pkg::IO_OP_W-1:0]   io_op;
    logic [PAGE_BITS-1:0]           io_page;
    logic                           last;
    logic [bpfm_pkg::COUNT_W-1:0]   read_count;
    logic [bpfm_pkg::COUNT_W-1:0]   write_count;

    modport source (output valid, output status, output frame, output io_op, output io_page,
                    output last, output read_count, output write_count, input ready);
    modport sink   (input valid, input status, input frame, input io_op, input io_page,
                    input last, input read_count, input write_count, output ready);
endinterface

### sv/bpfm_cfg_if.sv
// Configuration write channel: register index and write data.
interface bpfm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bpfm_pkg::CFG_IDX_W-1:0]    index;
    logic [bpfm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/buffer_pool_frame_manager.sv
// Top level of the buffer pool frame manager.
// Frame table of a page buffer pool with FIFO (policy 0) or LRU (policy 1) replacement. A
// request beat carries a mode and a page; it produces one or more result beats, the final one
// marked by last. A request is taken only when the previous one has issued all of its results
// into the result register, so requests are handled one at a time. Each request is taken from
// idle and then decoded; the decode alone finishes pin hits, fills of an empty frame, unpin,
// mark dirty, force, a flush with nothing dirty and the not-found and pinned error results.
// A pin that must evict first scans the usable frames one per cycle for a victim, then loads
// the page (after a write-back if the victim is dirty) or returns the no-frame error. Flush
// and clean shutdown with dirty frames walk the usable frames one per cycle, holding at a dirty
// frame while the result register is full; every other step that issues a result also waits
// while it is full. The result register lets a finished beat wait while the next request is
// taken. Configuration writes are always accepted and are meant for idle periods only; there is
// no clearing pass after reset.
module buffer_pool_frame_manager #(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 24,
    parameter int PIN_BITS   = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    bpfm_req_if.sink    req,
    bpfm_res_if.source  res,
    bpfm_cfg_if.sink    cfg
);

    bpfm_pkg::dp_cmd_t  cmd;
    bpfm_pkg::dp_stat_t stat;

    // config registers are plain flops: every write beat lands at once
    assign cfg.ready = 1'b1;

    bpfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpfm_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .PIN_BITS   (PIN_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_mode        (req.mode),
        .req_page        (req.page_num),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .res_ready       (res.ready),
        .res_valid       (res.valid),
        .res_status      (res.status),
        .res_frame       (res.frame),
        .res_io_op       (res.io_op),
        .res_io_page     (res.io_page),
        .res_last        (res.last),
        .res_read_count  (res.read_count),
        .res_write_count (res.write_count)
    );

endmodule

### sv/bpfm_ctrl.sv
// Request sequencer: decodes each request and steps the datapath through it.
module bpfm_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bpfm_pkg::dp_stat_t stat,
    output bpfm_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_VSCAN,
        S_EVICT,
        S_LOAD,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bpfm_pkg::OP_NONE;
        cmd.code   = bpfm_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = bpfm_pkg::OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                    unique case (stat.mode)
                        bpfm_pkg::MODE_PIN:
                        begin
                            if (stat.hit)
                                cmd.op = bpfm_pkg::OP_PIN_HIT;
                            else if (stat.empty)
                                cmd.op = bpfm_pkg::OP_FILL;
                            else
                            begin
                                cmd.op     = bpfm_pkg::OP_VSTART;
                                state_next = S_VSCAN;
                            end
                        end
                        bpfm_pkg::MODE_UNPIN, bpfm_pkg::MODE_DIRTY, bpfm_pkg::MODE_FORCE:
                        begin
                            if (!stat.hit)
                            begin
                                cmd.op   = bpfm_pkg::OP_CODE;
                                cmd.code = bpfm_pkg::ST_NOT_FOUND;
                            end
                            else if (stat.mode == bpfm_pkg::MODE_UNPIN)
                                cmd.op = bpfm_pkg::OP_UNPIN;
                            else if (stat.mode == bpfm_pkg::MODE_DIRTY)
                                cmd.op = bpfm_pkg::OP_DIRTY;
                            else
                                cmd.op = bpfm_pkg::OP_FORCE;
                        end
                        bpfm_pkg::MODE_FLUSH, bpfm_pkg::MODE_SHUTDOWN:
                        begin
                            if (stat.mode == bpfm_pkg::MODE_SHUTDOWN && stat.any_pinned)
                            begin
                                cmd.op   = bpfm_pkg::OP_CODE;
                                cmd.code = bpfm_pkg::ST_PINNED;
                            end
                            else if (stat.any_dirty)
                            begin
                                cmd.op     = bpfm_pkg::OP_FSTART;
                                state_next = S_FLUSH;
                            end
                            else
                                cmd.op = bpfm_pkg::OP_CODE;
                        end
                        default:
                            cmd.op = bpfm_pkg::OP_CODE;
                    endcase
                end
            end
            S_VSCAN:
            begin
                cmd.op = bpfm_pkg::OP_VSTEP;
                if (stat.scan_last)
                    state_next = S_EVICT;
            end
            S_EVICT:
            begin
                if (stat.out_free)
                begin
                    priority if (!stat.v_found)
                    begin
                        cmd.op     = bpfm_pkg::OP_CODE;
                        cmd.code   = bpfm_pkg::ST_NO_FRAME;
                        state_next = S_IDLE;
                    end
                    else if (stat.v_dirty)
                    begin
                        cmd.op     = bpfm_pkg::OP_WB;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.op     = bpfm_pkg::OP_LOAD;
                        state_next = S_IDLE;
                    end
                end
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = bpfm_pkg::OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (!stat.cur_dirty || stat.out_free)
                begin
                    cmd.op = bpfm_pkg::OP_FSTEP;
                    if (stat.scan_last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### sv/bpfm_dp.sv
// Frame table datapath: frame state, scans, totals, config and result register.
module bpfm_dp #(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 24,
    parameter int PIN_BITS   = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  bpfm_pkg::dp_cmd_t                  cmd,
    output bpfm_pkg::dp_stat_t                 stat,
    input  logic [bpfm_pkg::MODE_W-1:0]        req_mode,
    input  logic [PAGE_BITS-1:0]               req_page,
    input  logic                               cfg_we,
    input  logic [bpfm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpfm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               res_ready,
    output logic                               res_valid,
    output logic [bpfm_pkg::STATUS_W-1:0]      res_status,
    output logic [bpfm_pkg::FRAME_W-1:0]       res_frame,
    output logic [bpfm_pkg::IO_OP_W-1:0]       res_io_op,
    output logic [PAGE_BITS-1:0]               res_io_page,
    output logic                               res_last,
    output logic [bpfm_pkg::COUNT_W-1:0]       res_read_count,
    output logic [bpfm_pkg::COUNT_W-1:0]       res_write_count
);

    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int NW = IW + 1;

    typedef logic [NUM_FRAMES-1:0][IW-1:0] age_arr_t;
    typedef logic [NUM_FRAMES-1:0][PIN_BITS-1:0] pin_arr_t;

    // frame state
    logic [PAGE_BITS-1:0]  page_reg [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic [NUM_FRAMES-1:0] dirty_reg, dirty_next;
    pin_arr_t              pins_reg, pins_next;
    age_arr_t              age_reg, age_next;

    // request and scan state
    logic [bpfm_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [PAGE_BITS-1:0]        plat_reg, plat_next;
    logic [IW-1:0]               scan_reg, scan_next;
    logic                        vfound_reg, vfound_next;
    logic [IW-1:0]               victim_reg, victim_next;
    logic [IW-1:0]               best_reg, best_next;

    // totals and config
    logic [bpfm_pkg::COUNT_W-1:0] reads_reg, reads_next;
    logic [bpfm_pkg::COUNT_W-1:0] writes_reg, writes_next;
    logic                         policy_reg;
    logic [bpfm_pkg::LIMIT_W-1:0] limit_reg;

    // result register
    logic                           ovalid_reg, ovalid_next;
    logic [bpfm_pkg::STATUS_W-1:0]  ostatus_reg;
    logic [bpfm_pkg::FRAME_W-1:0]   oframe_reg;
    logic [bpfm_pkg::IO_OP_W-1:0]   oop_reg;
    logic [PAGE_BITS-1:0]           opage_reg;
    logic                           olast_reg;
    logic [bpfm_pkg::COUNT_W-1:0]   orc_reg, owc_reg;

    logic                           emit;
    logic [bpfm_pkg::STATUS_W-1:0]  e_status;
    logic [IW-1:0]                  e_frame;
    logic [bpfm_pkg::IO_OP_W-1:0]   e_op;
    logic [PAGE_BITS-1:0]           e_page;
    logic                           e_last;

    logic                  page_we;
    logic [IW-1:0]         page_wa;
    logic [IW-1:0]         rd_addr;
    logic [PAGE_BITS-1:0]  page_rd;

    logic [NW-1:0]         n_use;
    logic [NUM_FRAMES-1:0] usable, match, live_dirty, live_pinned, later_dirty;
    logic                  hit, empty;
    logic [IW-1:0]         hit_idx, empty_idx;
    logic                  out_free;

    function automatic age_arr_t newest(input age_arr_t a, input logic [NUM_FRAMES-1:0] v,
                                        input logic [IW-1:0] f, input logic was_valid);
        age_arr_t  r;
        logic [IW:0] lim;
        r   = a;
        lim = was_valid ? {1'b0, a[f]} : {1'b1, {IW{1'b0}}};
        for (int g = 0; g < NUM_FRAMES; g++)
        begin
            if (IW'(g) != f && v[g] && {1'b0, a[g]} < lim)
                r[g] = a[g] + 1'b1;
        end
        r[f] = '0;
        return r;
    endfunction

    // frame limit clamped to 1 .. NUM_FRAMES
    always_comb
    begin
        if (limit_reg == '0)
            n_use = NW'(1);
        else if (32'(limit_reg) > NUM_FRAMES)
            n_use = NW'(NUM_FRAMES);
        else
            n_use = NW'(limit_reg);
    end

    always_comb
    begin
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            usable[f]      = NW'(f) < n_use;
            match[f]       = usable[f] && valid_reg[f] && (page_reg[f] == plat_reg);
            live_dirty[f]  = usable[f] && valid_reg[f] && dirty_reg[f];
            live_pinned[f] = usable[f] && valid_reg[f] && (pins_reg[f] != '0);
            later_dirty[f] = live_dirty[f] && (NW'(f) > {1'b0, scan_reg});
        end
    end

    // lowest index wins
    always_comb
    begin
        hit       = 1'b0;
        hit_idx   = '0;
        empty     = 1'b0;
        empty_idx = '0;
        for (int f = NUM_FRAMES - 1; f >= 0; f--)
        begin
            if (match[f])
            begin
                hit     = 1'b1;
                hit_idx = IW'(f);
            end
            if (usable[f] && !valid_reg[f])
            begin
                empty     = 1'b1;
                empty_idx = IW'(f);
            end
        end
    end

    assign out_free = !ovalid_reg || res_ready;

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.hit        = hit;
        stat.empty      = empty;
        stat.any_dirty  = |live_dirty;
        stat.any_pinned = |live_pinned;
        stat.v_found    = vfound_reg;
        stat.v_dirty    = dirty_reg[victim_reg];
        stat.scan_last  = ({1'b0, scan_reg} == n_use - NW'(1));
        stat.cur_dirty  = valid_reg[scan_reg] && dirty_reg[scan_reg];
        stat.out_free   = out_free;
    end

    always_comb
    begin
        unique case (cmd.op)
            bpfm_pkg::OP_WB:    rd_addr = victim_reg;
            bpfm_pkg::OP_FSTEP: rd_addr = scan_reg;
            default:            rd_addr = hit_idx;
        endcase
    end

    assign page_rd = page_reg[rd_addr];

    always_comb
    begin
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        pins_next   = pins_reg;
        age_next    = age_reg;
        mode_next   = mode_reg;
        plat_next   = plat_reg;
        scan_next   = scan_reg;
        vfound_next = vfound_reg;
        victim_next = victim_reg;
        best_next   = best_reg;
        reads_next  = reads_reg;
        writes_next = writes_reg;
        page_we     = 1'b0;
        page_wa     = empty_idx;
        emit        = 1'b0;
        e_status    = bpfm_pkg::ST_OK;
        e_frame     = '0;
        e_op        = bpfm_pkg::IO_NONE;
        e_page      = '0;
        e_last      = 1'b1;
        unique case (cmd.op)
            bpfm_pkg::OP_LATCH:
            begin
                mode_next = req_mode;
                plat_next = req_page;
            end
            bpfm_pkg::OP_PIN_HIT:
            begin
                if (pins_reg[hit_idx] != '1)
                    pins_next[hit_idx] = pins_reg[hit_idx] + 1'b1;
                if (policy_reg)
                    age_next = newest(age_reg, valid_reg, hit_idx, 1'b1);
                emit    = 1'b1;
                e_frame = hit_idx;
            end
            bpfm_pkg::OP_UNPIN:
            begin
                if (pins_reg[hit_idx] != '0)
                    pins_next[hit_idx] = pins_reg[hit_idx] - 1'b1;
                emit    = 1'b1;
                e_frame = hit_idx;
            end
            bpfm_pkg::OP_DIRTY:
            begin
                dirty_next[hit_idx] = 1'b1;
                emit    = 1'b1;
                e_frame = hit_idx;
            end
            bpfm_pkg::OP_FORCE:
            begin
                dirty_next[hit_idx] = 1'b0;
                if (writes_reg != '1)
                    writes_next = writes_reg + 1'b1;
                emit    = 1'b1;
                e_frame = hit_idx;
                e_op    = bpfm_pkg::IO_WRITE;
                e_page  = page_rd;
            end
            bpfm_pkg::OP_CODE:
            begin
                emit     = 1'b1;
                e_status = cmd.code;
            end
            bpfm_pkg::OP_FILL:
            begin
                age_next              = newest(age_reg, valid_reg, empty_idx, 1'b0);
                valid_next[empty_idx] = 1'b1;
                pins_next[empty_idx]  = PIN_BITS'(1);
                dirty_next[empty_idx] = 1'b0;
                page_we               = 1'b1;
                page_wa               = empty_idx;
                if (reads_reg != '1)
                    reads_next = reads_reg + 1'b1;
                emit    = 1'b1;
                e_frame = empty_idx;
                e_op    = bpfm_pkg::IO_READ;
                e_page  = plat_reg;
            end
            bpfm_pkg::OP_VSTART:
            begin
                scan_next   = '0;
                vfound_next = 1'b0;
            end
            bpfm_pkg::OP_VSTEP:
            begin
                if (pins_reg[scan_reg] == '0 && (!vfound_reg || age_reg[scan_reg] > best_reg))
                begin
                    vfound_next = 1'b1;
                    victim_next = scan_reg;
                    best_next   = age_reg[scan_reg];
                end
                scan_next = scan_reg + 1'b1;
            end
            bpfm_pkg::OP_WB:
            begin
                if (writes_reg != '1)
                    writes_next = writes_reg + 1'b1;
                emit    = 1'b1;
                e_frame = victim_reg;
                e_op    = bpfm_pkg::IO_WRITE;
                e_page  = page_rd;
                e_last  = 1'b0;
            end
            bpfm_pkg::OP_LOAD:
            begin
                age_next               = newest(age_reg, valid_reg, victim_reg, 1'b1);
                pins_next[victim_reg]  = PIN_BITS'(1);
                dirty_next[victim_reg] = 1'b0;
                page_we                = 1'b1;
                page_wa                = victim_reg;
                if (reads_reg != '1)
                    reads_next = reads_reg + 1'b1;
                emit    = 1'b1;
                e_frame = victim_reg;
                e_op    = bpfm_pkg::IO_READ;
                e_page  = plat_reg;
            end
            bpfm_pkg::OP_FSTART:
                scan_next = '0;
            bpfm_pkg::OP_FSTEP:
            begin
                if (valid_reg[scan_reg] && dirty_reg[scan_reg])
                begin
                    dirty_next[scan_reg] = 1'b0;
                    if (writes_reg != '1)
                        writes_next = writes_reg + 1'b1;
                    emit    = 1'b1;
                    e_frame = scan_reg;
                    e_op    = bpfm_pkg::IO_WRITE;
                    e_page  = page_rd;
                    e_last  = !(|later_dirty);
                end
                scan_next = scan_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        ovalid_next = emit || (ovalid_reg && !res_ready);
    end

    always_ff @(posedge clk)
    begin
        if (page_we)
            page_reg[page_wa] <= plat_reg;
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        plat_reg   <= plat_next;
        victim_reg <= victim_next;
        best_reg   <= best_next;
        if (emit)
        begin
            ostatus_reg <= e_status;
            oframe_reg  <= bpfm_pkg::FRAME_W'(e_frame);
            oop_reg     <= e_op;
            opage_reg   <= e_page;
            olast_reg   <= e_last;
            orc_reg     <= reads_next;
            owc_reg     <= writes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            dirty_reg  <= '0;
            pins_reg   <= '0;
            age_reg    <= '0;
            scan_reg   <= '0;
            vfound_reg <= 1'b0;
            reads_reg  <= '0;
            writes_reg <= '0;
            ovalid_reg <= 1'b0;
            policy_reg <= 1'b0;
            limit_reg  <= bpfm_pkg::LIMIT_RESET;
        end
        else
        begin
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            pins_reg   <= pins_next;
            age_reg    <= age_next;
            scan_reg   <= scan_next;
            vfound_reg <= vfound_next;
            reads_reg  <= reads_next;
            writes_reg <= writes_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we && cfg_index == bpfm_pkg::CFG_POLICY)
                policy_reg <= cfg_data[0];
            if (cfg_we && cfg_index == bpfm_pkg::CFG_FRAMES)
                limit_reg <= cfg_data[bpfm_pkg::LIMIT_W-1:0];
        end
    end

    assign res_valid       = ovalid_reg;
    assign res_status      = ostatus_reg;
    assign res_frame       = oframe_reg;
    assign res_io_op       = oop_reg;
    assign res_io_page     = opage_reg;
    assign res_last        = olast_reg;
    assign res_read_count  = orc_reg;
    assign res_write_count = owc_reg;

endmodule

### sv/bpfm_checker.sv
// Port-level checks of the buffer pool frame manager, bound to the top level.
module bpfm_checker #(parameter int PAGE_BITS = 24)
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [bpfm_pkg::STATUS_W-1:0]   res_status,
    input logic [bpfm_pkg::IO_OP_W-1:0]    res_io_op,
    input logic [PAGE_BITS-1:0]            res_io_page,
    input logic                            res_last,
    input logic [bpfm_pkg::COUNT_W-1:0]    res_read_count,
    input logic [bpfm_pkg::COUNT_W-1:0]    res_write_count
);

    // stalled result beat stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // an error result carries no storage request and ends its request
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != bpfm_pkg::ST_OK |-> res_io_op == bpfm_pkg::IO_NONE && res_last)
        else $error("error result with storage request or not last");

    // no storage request means no page
    a_nopage: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_io_op == bpfm_pkg::IO_NONE |-> res_io_page == '0)
        else $error("io_page set without storage request");

    // totals never go down between shown beats
    a_mono: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && $past(res_valid) |->
            res_read_count >= $past(res_read_count) && res_write_count >= $past(res_write_count))
        else $error("totals decreased");

endmodule

bind buffer_pool_frame_manager bpfm_checker #(.PAGE_BITS(PAGE_BITS)) u_bpfm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_status      (res.status),
    .res_io_op       (res.io_op),
    .res_io_page     (res.io_page),
    .res_last        (res.last),
    .res_read_count  (res.read_count),
    .res_write_count (res.write_count)
);

### tb/bpfm_tb_if.sv
// Testbench package: packed result record used by the scoreboard.
`timescale 1ns / 100ps
package bpfm_tb_pkg;
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  frame;
        logic [1:0]  io_op;
        logic [23:0] io_page;
        logic        last;
        logic [31:0] read_count;
        logic [31:0] write_count;
    } frame_result_t;
endpackage

### tb/tb_buffer_pool_frame_manager.sv
// Testbench of the buffer pool frame manager: scoreboard against a behavioral frame table.
`timescale 1ns / 100ps
module tb_buffer_pool_frame_manager;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    bpfm_req_if req ();
    bpfm_res_if res ();
    bpfm_cfg_if cfg ();

    buffer_pool_frame_manager dut (.clk(clk), .rst_n(rst_n), .req(req), .res(res), .cfg(cfg));

    // Behavioral copy of the frame table
    logic        pol_lru;
    logic [4:0]  limit_reg;
    logic [23:0] fpage [16];
    logic        fvalid [16];
    logic [7:0]  fpins [16];
    logic        fdirty [16];
    logic [4:0]  fage [16];
    logic [31:0] reads_sum, writes_sum;

    bpfm_tb_pkg::frame_result_t pending_results [$];
    int  errors = 0;
    int  cycles = 0;
    int  idle_pct = 38;
    bit  hold_res = 1'b0;

    // Generous cycle cap
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int usable_frames();
        if (limit_reg == 0) return 1;
        if (limit_reg > 16) return 16;
        return limit_reg;
    endfunction

    function automatic void push_result(logic [1:0] st, int fr, logic [1:0] op,
                                        logic [23:0] pg, logic lst);
        bpfm_tb_pkg::frame_result_t r;
        r.status = st; r.frame = fr[3:0]; r.io_op = op; r.io_page = pg; r.last = lst;
        r.read_count = reads_sum; r.write_count = writes_sum;
        pending_results.push_back(r);
    endfunction

    function automatic void bump_writes();
        if (writes_sum != 32'hFFFF_FFFF) writes_sum++;
    endfunction

    // Move frame f to age 0; younger frames age by one
    function automatic void touch_frame(int f, bit was_valid);
        logic [5:0] a;
        a = was_valid ? {1'b0, fage[f]} : 6'h3F;
        for (int g = 0; g < 16; g++)
            if (g != f && fvalid[g] && {1'b0, fage[g]} < a) fage[g]++;
        fage[f] = 0;
    endfunction

    function automatic int lookup_page(logic [23:0] pg);
        for (int f = 0; f < usable_frames(); f++)
            if (fvalid[f] && fpage[f] == pg) return f;
        return -1;
    endfunction

    function automatic void predict_flush();
        int n, cnt, done;
        n = usable_frames(); cnt = 0; done = 0;
        for (int f = 0; f < n; f++) if (fvalid[f] && fdirty[f]) cnt++;
        if (cnt == 0)
        begin
            push_result(bpfm_pkg::ST_OK, 0, bpfm_pkg::IO_NONE, '0, 1'b1);
            return;
        end
        for (int f = 0; f < n; f++)
            if (fvalid[f] && fdirty[f])
            begin
                fdirty[f] = 1'b0;
                bump_writes();
                done++;
                push_result(bpfm_pkg::ST_OK, f, bpfm_pkg::IO_WRITE, fpage[f], done == cnt);
            end
    endfunction

    function automatic void predict_pin(logic [23:0] pg);
        int n, hit, slot;
        logic [4:0] best;
        n = usable_frames(); hit = lookup_page(pg); slot = -1; best = 0;
        if (hit >= 0)
        begin
            if (fpins[hit] != 8'hFF) fpins[hit]++;
            if (pol_lru) touch_frame(hit, 1'b1);
            push_result(bpfm_pkg::ST_OK, hit, bpfm_pkg::IO_NONE, '0, 1'b1);
            return;
        end
        for (int f = 0; f < n; f++)
            if (!fvalid[f])
            begin
                slot = f;
                break;
            end
        if (slot >= 0)
        begin
            touch_frame(slot, 1'b0);
            fvalid[slot] = 1'b1;
        end
        else
        begin
            for (int f = 0; f < n; f++)
                if (fpins[f] == 0 && (slot < 0 || fage[f] > best))
                begin
                    slot = f;
                    best = fage[f];
                end
            if (slot < 0)
            begin
                push_result(bpfm_pkg::ST_NO_FRAME, 0, bpfm_pkg::IO_NONE, '0, 1'b1);
                return;
            end
            if (fdirty[slot])
            begin
                bump_writes();
                push_result(bpfm_pkg::ST_OK, slot, bpfm_pkg::IO_WRITE, fpage[slot], 1'b0);
            end
            touch_frame(slot, 1'b1);
        end
        fpage[slot] = pg; fpins[slot] = 1; fdirty[slot] = 1'b0;
        if (reads_sum != 32'hFFFF_FFFF) reads_sum++;
        push_result(bpfm_pkg::ST_OK, slot, bpfm_pkg::IO_READ, pg, 1'b1);
    endfunction

    function automatic void predict_request(logic [2:0] md, logic [23:0] pg);
        int hit;
        case (md)
            bpfm_pkg::MODE_PIN: predict_pin(pg);
            bpfm_pkg::MODE_UNPIN, bpfm_pkg::MODE_DIRTY, bpfm_pkg::MODE_FORCE:
            begin
                hit = lookup_page(pg);
                if (hit < 0) push_result(bpfm_pkg::ST_NOT_FOUND, 0, bpfm_pkg::IO_NONE, '0, 1'b1);
                else if (md == bpfm_pkg::MODE_UNPIN)
                begin
                    if (fpins[hit] != 0) fpins[hit]--;
                    push_result(bpfm_pkg::ST_OK, hit, bpfm_pkg::IO_NONE, '0, 1'b1);
                end
                else if (md == bpfm_pkg::MODE_DIRTY)
                begin
                    fdirty[hit] = 1'b1;
                    push_result(bpfm_pkg::ST_OK, hit, bpfm_pkg::IO_NONE, '0, 1'b1);
                end
                else
                begin
                    fdirty[hit] = 1'b0;
                    bump_writes();
                    push_result(bpfm_pkg::ST_OK, hit, bpfm_pkg::IO_WRITE, fpage[hit], 1'b1);
                end
            end
            bpfm_pkg::MODE_FLUSH: predict_flush();
            bpfm_pkg::MODE_SHUTDOWN:
            begin
                for (int f = 0; f < usable_frames(); f++)
                    if (fvalid[f] && fpins[f] != 0)
                    begin
                        push_result(bpfm_pkg::ST_PINNED, 0, bpfm_pkg::IO_NONE, '0, 1'b1);
                        return;
                    end
                predict_flush();
            end
            default: push_result(bpfm_pkg::ST_OK, 0, bpfm_pkg::IO_NONE, '0, 1'b1);
        endcase
    endfunction

    // Send one request beat; idles at random first
    task automatic send_request(logic [2:0] md, logic [23:0] pg);
        while ($urandom_range(99) < idle_pct) @(posedge clk);
        req.valid <= 1'b1;
        req.mode <= md;
        req.page_num <= pg;
        do @(posedge clk); while (!req.ready);
        predict_request(md, pg);
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_register(logic [3:0] idx, logic [7:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == bpfm_pkg::CFG_POLICY) pol_lru = val[0];
        else if (idx == bpfm_pkg::CFG_FRAMES) limit_reg = val[4:0];
        @(posedge clk);
    endtask

    // Wait for the block to drain, then a latency margin
    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Result ready: random stalls unless held off
    always @(posedge clk)
    begin
        if (!rst_n) res.ready <= 1'b0;
        else res.ready <= !hold_res && ($urandom_range(99) >= idle_pct);
    end

    // Scoreboard
    always @(posedge clk)
    begin
        bpfm_tb_pkg::frame_result_t got, want;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.status, res.frame, res.io_op, res.io_page, res.last,
                    res.read_count, res.write_count};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                if (got.frame !== want.frame)
                    $display("%0t: frame expected %0d actual %0d", $time, want.frame, got.frame);
                if (got.io_op !== want.io_op)
                    $display("%0t: io_op expected %0d actual %0d", $time, want.io_op, got.io_op);
                if (got.io_page !== want.io_page)
                    $display("%0t: io_page expected %h actual %h", $time, want.io_page,
                             got.io_page);
                if (got.last !== want.last)
                    $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                if (got.read_count !== want.read_count)
                    $display("%0t: read_count expected %0d actual %0d", $time, want.read_count,
                             got.read_count);
                if (got.write_count !== want.write_count)
                    $display("%0t: write_count expected %0d actual %0d", $time,
                             want.write_count, got.write_count);
                if (got !== want) errors++;
            end
        end
    end

    // Random page from a small set so hits and evictions happen, sometimes extremes
    function automatic logic [23:0] pick_page();
        case ($urandom_range(9))
            0: return 24'hFFFFFF;
            1: return 24'($urandom());
            default: return 24'($urandom_range(11));
        endcase
    endfunction

    // Extremes, every mode, special cases
    task automatic test_directed();
        send_request(bpfm_pkg::MODE_FLUSH, 24'h0);          // flush with nothing dirty
        send_request(bpfm_pkg::MODE_UNPIN, 24'h0);          // page not found
        send_request(bpfm_pkg::MODE_PIN, 24'h0);
        send_request(bpfm_pkg::MODE_PIN, 24'hFFFFFF);
        send_request(bpfm_pkg::MODE_PIN, 24'hFFFFFF);       // hit
        send_request(bpfm_pkg::MODE_SHUTDOWN, 24'h0);       // pinned pages remain
        send_request(bpfm_pkg::MODE_DIRTY, 24'hFFFFFF);
        send_request(bpfm_pkg::MODE_FORCE, 24'h0);          // force a clean frame
        send_request(bpfm_pkg::MODE_UNPIN, 24'h0);
        send_request(bpfm_pkg::MODE_UNPIN, 24'h0);          // unpin at zero
        send_request(bpfm_pkg::MODE_UNPIN, 24'hFFFFFF);
        send_request(bpfm_pkg::MODE_UNPIN, 24'hFFFFFF);
        send_request(bpfm_pkg::MODE_DIRTY, 24'h0);
        send_request(bpfm_pkg::MODE_SHUTDOWN, 24'h0);       // clean shutdown flushes
        send_request(3'd6, 24'h123456);
        send_request(3'd7, 24'hABCDEF);
        send_request(bpfm_pkg::MODE_DIRTY, 24'h555555);
        send_request(bpfm_pkg::MODE_FORCE, 24'hAAAAAA);
        drain();
    endtask

    // Tiny pool: eviction with dirty victim and no unpinned frame
    task automatic test_small_pool(logic lru, logic [7:0] lim);
        write_register(bpfm_pkg::CFG_POLICY, {7'd0, lru});
        write_register(bpfm_pkg::CFG_FRAMES, lim);
        for (int i = 0; i < 6; i++)
        begin
            send_request(bpfm_pkg::MODE_PIN, 24'(24'h100 + i));
            if (i[0]) send_request(bpfm_pkg::MODE_DIRTY, 24'(24'h100 + i));
            send_request(bpfm_pkg::MODE_UNPIN, 24'(24'h100 + i));
        end
        send_request(bpfm_pkg::MODE_PIN, 24'h200);
        send_request(bpfm_pkg::MODE_PIN, 24'h201);
        send_request(bpfm_pkg::MODE_PIN, 24'h202);          // may find no unpinned frame
        send_request(bpfm_pkg::MODE_UNPIN, 24'h200);
        send_request(bpfm_pkg::MODE_UNPIN, 24'h201);
        drain();
    endtask

    // Random mix of requests
    task automatic test_random(int count, logic lru, logic [7:0] lim);
        logic [2:0] md;
        write_register(bpfm_pkg::CFG_POLICY, {7'd0, lru});
        write_register(bpfm_pkg::CFG_FRAMES, lim);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: md = bpfm_pkg::MODE_PIN;
                7, 8, 9, 10, 11:     md = bpfm_pkg::MODE_UNPIN;
                12, 13, 14:          md = bpfm_pkg::MODE_DIRTY;
                15:                  md = bpfm_pkg::MODE_FORCE;
                16:                  md = bpfm_pkg::MODE_FLUSH;
                17:                  md = bpfm_pkg::MODE_SHUTDOWN;
                default:             md = 3'($urandom_range(7));
            endcase
            send_request(md, pick_page());
        end
        drain();
    endtask

    // Receiver holds off while requests keep coming
    task automatic test_backpressure();
        fork
        begin
            hold_res = 1'b1;
            repeat (300) @(posedge clk);
            hold_res = 1'b0;
        end
        for (int i = 0; i < 12; i++) send_request(bpfm_pkg::MODE_FLUSH, 24'h0);
        join
        drain();
    endtask

    initial
    begin
        req.valid = 1'b0; req.mode = '0; req.page_num = '0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        pol_lru = 1'b0; limit_reg = 5'd16;
        reads_sum = 0; writes_sum = 0;
        for (int f = 0; f < 16; f++)
        begin
            fpage[f] = '0; fvalid[f] = 1'b0; fpins[f] = '0; fdirty[f] = 1'b0; fage[f] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_small_pool(1'b0, 8'd2);
        test_small_pool(1'b1, 8'd0);              // limit 0 acts as one frame
        test_backpressure();
        idle_pct = 0;                             // stretch with no idling
        test_random(10, 1'b1, 8'd31);             // above the frame count
        idle_pct = 38;
        test_random(10, 1'b0, 8'd16);
        test_random(10, 1'b1, 8'd3);
        test_random(10, 1'b0, 8'd1);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### buffer_pool_frame_manager.f
sv/bpfm_pkg.sv
sv/bpfm_req_if.sv
sv/bpfm_res_if.sv
sv/bpfm_cfg_if.sv
sv/bpfm_ctrl.sv
sv/bpfm_dp.sv
sv/buffer_pool_frame_manager.sv
sv/bpfm_checker.sv
tb/bpfm_tb_if.sv
tb/tb_buffer_pool_frame_manager.sv
